[design/idur_pkg.sv]
// shared types and constants for the iso-8601 duration parser
// no dependencies; used by the interfaces and every module of the block
`default_nettype none

package idur_pkg;

    localparam int CHAR_W = 8;
    localparam int SEC_W  = 63;
    localparam int DIG_W  = 64;
    localparam int SCALE_W = 17;
    localparam int NUM_SCALED = 3;

    localparam logic [SEC_W-1:0] MAX_SECONDS_RESET = 63'd86400;
    localparam logic [DIG_W-1:0] DIGIT_LIMIT = 64'd1844674407370955160;

    // scaled accumulator slots
    localparam int SC_DAY  = 0;
    localparam int SC_HOUR = 1;
    localparam int SC_MIN  = 2;

    localparam logic [SCALE_W-1:0] UNIT_SCALE [NUM_SCALED] =
        '{17'd86400, 17'd3600, 17'd60};

    localparam logic [CHAR_W-1:0] CH_P    = 8'h50;
    localparam logic [CHAR_W-1:0] CH_T    = 8'h54;
    localparam logic [CHAR_W-1:0] CH_D    = 8'h44;
    localparam logic [CHAR_W-1:0] CH_H    = 8'h48;
    localparam logic [CHAR_W-1:0] CH_M    = 8'h4d;
    localparam logic [CHAR_W-1:0] CH_S    = 8'h53;
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;

    typedef enum logic [2:0] {
        PH_START   = 3'b001,
        PH_AFTER_P = 3'b010,
        PH_BODY    = 3'b100
    } phase_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
    } char_item_t;

    // input register contents handed to the parse core
    typedef struct packed {
        logic       valid;
        char_item_t item;
    } stage_t;

endpackage

`default_nettype wire

[design/idur_in_if.sv]
// character channel: valid/ready handshake with one byte and a last flag
// depends on idur_pkg
`default_nettype none

interface idur_in_if;
    logic                           valid;
    logic                           ready;
    logic [idur_pkg::CHAR_W-1:0]    char_code;
    logic                           is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

`default_nettype wire

[design/idur_out_if.sv]
// result channel: valid/ready handshake with error flag and seconds
// depends on idur_pkg
`default_nettype none

interface idur_out_if;
    logic                           valid;
    logic                           ready;
    logic                           parse_error;
    logic [idur_pkg::SEC_W-1:0]     duration_seconds;

    modport source (output valid, output parse_error, output duration_seconds, input ready);
    modport sink   (input valid, input parse_error, input duration_seconds, output ready);
endinterface

`default_nettype wire

[design/iso8601_duration_to_seconds_top.sv]
// Streaming ISO-8601 duration parser: takes one byte per cycle while the result
// is not stalled and answers once per string with an error flag and the clamped
// seconds. The per-byte state update closes through the parse state registers
// alone, so bytes are accepted back to back. The last byte passes through the
// input register and then the result register, and a stalled result holds back
// only a following last byte.
// max_seconds may be written only while no string is in flight.
// depends on idur_pkg, idur_in_if, idur_out_if, idur_in_stage, idur_parse_core
`default_nettype none

module iso8601_duration_to_seconds_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    idur_in_if.sink                          chars,
    idur_out_if.source                       result,
    input  wire logic                        cfg_wr_en,
    input  wire logic [idur_pkg::SEC_W-1:0]  cfg_wr_data
);

    idur_pkg::stage_t  stage;
    logic              take;

    idur_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .take  (take),
        .stage (stage)
    );

    idur_parse_core u_parse_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stage       (stage),
        .take        (take),
        .result      (result)
    );

endmodule

`default_nettype wire

[design/idur_in_stage.sv]
// input register for the character channel
// depends on idur_pkg and idur_in_if
`default_nettype none

module idur_in_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    idur_in_if.sink              chars,
    input  wire logic            take,
    output idur_pkg::stage_t     stage
);

    logic                  valid_reg;
    idur_pkg::char_item_t  item_reg;
    logic                  load;

    // free when empty or when the held byte moves on this cycle
    assign chars.ready = !valid_reg || take;
    assign load        = chars.valid && chars.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.char_code <= chars.char_code;
            item_reg.is_last   <= chars.is_last;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

`default_nettype wire

[design/idur_parse_core.sv]
// per-byte parse state, component accumulation and the result register
// depends on idur_pkg and idur_out_if
`default_nettype none

module idur_parse_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [idur_pkg::SEC_W-1:0]  cfg_wr_data,
    input  wire idur_pkg::stage_t            stage,
    output logic                             take,
    idur_out_if.source                       result
);

    localparam int SW = idur_pkg::SEC_W;
    localparam int DW = idur_pkg::DIG_W;
    localparam int NS = idur_pkg::NUM_SCALED;

    logic [SW-1:0]          max_reg;
    idur_pkg::phase_t       phase_reg, phase_next;
    logic [DW-1:0]          digit_reg, digit_next;
    logic                   have_reg, have_next;
    logic [SW-1:0]          total_reg, total_next;
    logic                   saw_reg, saw_next;
    logic                   failed_reg, failed_next;
    // digit run times each unit scale, with a flag once it reaches 2^63
    logic [SW-1:0]          scaled_reg [NS];
    logic [SW-1:0]          scaled_next [NS];
    logic                   over_reg [NS];
    logic                   over_next [NS];

    logic                   out_valid_reg;
    logic                   err_reg, err_next;
    logic [SW-1:0]          secs_reg, secs_next;

    logic [7:0]             c;
    logic                   last;
    logic                   is_digit;
    logic [3:0]             dval;
    logic                   in_body;
    logic [DW-1:0]          dig10;
    logic [SW+3:0]          sc_sum [NS];
    logic [SW-1:0]          sel_scaled;
    logic                   sel_over;
    logic                   unit_ok;
    logic [SW:0]            add_sum;
    logic [SW-1:0]          secs_floor;

    assign c    = stage.item.char_code;
    assign last = stage.item.is_last;
    assign take = stage.valid && (!last || !out_valid_reg || result.ready);

    assign is_digit = (c inside {[idur_pkg::CH_ZERO:idur_pkg::CH_NINE]});
    assign dval     = c[3:0];
    // only used while the run is at or below the digit limit, so it cannot wrap
    assign dig10    = (digit_reg << 3) + (digit_reg << 1) + DW'(dval);

    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            sc_sum[i] = ({4'b0, scaled_reg[i]} << 3) + ({4'b0, scaled_reg[i]} << 1)
                        + (SW+4)'(dval * idur_pkg::UNIT_SCALE[i]);
        end
    end

    // pick the product of the open run and the unit just seen
    always_comb
    begin
        unit_ok    = 1'b1;
        sel_scaled = digit_reg[SW-1:0];
        sel_over   = digit_reg[DW-1];
        case (c)
            idur_pkg::CH_D:
            begin
                sel_scaled = scaled_reg[idur_pkg::SC_DAY];
                sel_over   = over_reg[idur_pkg::SC_DAY];
            end
            idur_pkg::CH_H:
            begin
                sel_scaled = scaled_reg[idur_pkg::SC_HOUR];
                sel_over   = over_reg[idur_pkg::SC_HOUR];
            end
            idur_pkg::CH_M:
            begin
                sel_scaled = scaled_reg[idur_pkg::SC_MIN];
                sel_over   = over_reg[idur_pkg::SC_MIN];
            end
            idur_pkg::CH_S:
            begin
                sel_scaled = digit_reg[SW-1:0];
                sel_over   = digit_reg[DW-1];
            end
            default:
            begin
                unit_ok = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, sel_scaled} + {1'b0, total_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        digit_next  = digit_reg;
        have_next   = have_reg;
        total_next  = total_reg;
        saw_next    = saw_reg;
        failed_next = failed_reg;
        for (int i = 0; i < NS; i++)
        begin
            scaled_next[i] = scaled_reg[i];
            over_next[i]   = over_reg[i];
        end
        in_body = 1'b0;

        if (!failed_reg)
        begin
            case (phase_reg)
                idur_pkg::PH_START:
                begin
                    if (c == idur_pkg::CH_P)
                    begin
                        phase_next = idur_pkg::PH_AFTER_P;
                    end
                    else
                    begin
                        phase_next = idur_pkg::PH_BODY;
                        in_body    = (c != idur_pkg::CH_T);
                    end
                end
                idur_pkg::PH_AFTER_P:
                begin
                    phase_next = idur_pkg::PH_BODY;
                    in_body    = (c != idur_pkg::CH_T);
                end
                default:
                begin
                    phase_next = idur_pkg::PH_BODY;
                    in_body    = 1'b1;
                end
            endcase
        end

        if (in_body)
        begin
            if (is_digit)
            begin
                if (digit_reg > idur_pkg::DIGIT_LIMIT)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    digit_next = dig10;
                    have_next  = 1'b1;
                    for (int i = 0; i < NS; i++)
                    begin
                        scaled_next[i] = sc_sum[i][SW-1:0];
                        over_next[i]   = over_reg[i] || (|sc_sum[i][SW+3:SW]);
                    end
                end
            end
            else if (!unit_ok || !have_reg || sel_over || add_sum[SW])
            begin
                failed_next = 1'b1;
            end
            else
            begin
                total_next = add_sum[SW-1:0];
                digit_next = '0;
                have_next  = 1'b0;
                saw_next   = 1'b1;
                for (int i = 0; i < NS; i++)
                begin
                    scaled_next[i] = '0;
                    over_next[i]   = 1'b0;
                end
            end
        end
    end

    // answer from the state as it stands after this byte
    assign secs_floor = (total_next == '0) ? SW'(1) : total_next;
    assign err_next   = failed_next || have_next || !saw_next;
    assign secs_next  = err_next ? '0 :
                        ((secs_floor > max_reg) ? max_reg : secs_floor);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= idur_pkg::MAX_SECONDS_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= idur_pkg::PH_START;
            digit_reg  <= '0;
            have_reg   <= 1'b0;
            total_reg  <= '0;
            saw_reg    <= 1'b0;
            failed_reg <= 1'b0;
            for (int i = 0; i < NS; i++)
            begin
                scaled_reg[i] <= '0;
                over_reg[i]   <= 1'b0;
            end
        end
        else if (take)
        begin
            if (last)
            begin
                // string closed: start over for the next one
                phase_reg  <= idur_pkg::PH_START;
                digit_reg  <= '0;
                have_reg   <= 1'b0;
                total_reg  <= '0;
                saw_reg    <= 1'b0;
                failed_reg <= 1'b0;
                for (int i = 0; i < NS; i++)
                begin
                    scaled_reg[i] <= '0;
                    over_reg[i]   <= 1'b0;
                end
            end
            else
            begin
                phase_reg  <= phase_next;
                digit_reg  <= digit_next;
                have_reg   <= have_next;
                total_reg  <= total_next;
                saw_reg    <= saw_next;
                failed_reg <= failed_next;
                for (int i = 0; i < NS; i++)
                begin
                    scaled_reg[i] <= scaled_next[i];
                    over_reg[i]   <= over_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take && last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && last)
        begin
            err_reg  <= err_next;
            secs_reg <= secs_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.parse_error      = err_reg;
    assign result.duration_seconds = secs_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && err_reg |-> secs_reg == '0)
        else $error("error result carries nonzero seconds");

    a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !err_reg |-> secs_reg <= max_reg)
        else $error("valid result above the configured maximum");

    a_run_closed: assert property (@(posedge clk) disable iff (!rst_n)
        !have_reg |-> digit_reg == '0 && !over_reg[idur_pkg::SC_DAY])
        else $error("digit run value left behind after its unit");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        take && last |=> phase_reg == idur_pkg::PH_START && !failed_reg
                         && total_reg == '0 && !saw_reg)
        else $error("parse state not cleared after the last byte");

endmodule

`default_nettype wire
